>>> rtl/core/gn23_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn23_pkg
// Shared types, widths and the gradient table of the gradient noise core.
// ----------------------------------------------------------------------------
package gn23_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PERM_SIZE = 256;
    localparam int HASH_W    = 8;
    localparam int CELL_LSB  = FRAC_BITS;
    localparam int FADE_W    = FRAC_BITS + 1;
    localparam int DELTA_W   = FRAC_BITS + 2;
    localparam int VAL_W     = FRAC_BITS + 5;
    localparam int OUT_W     = 20;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_NOISE2D = 2'd1,
        REQ_NOISE3D = 2'd2
    } req_type_t;

    typedef struct packed {
        logic signed [1:0] gx;
        logic signed [1:0] gy;
        logic signed [1:0] gz;
    } grad_t;

    function automatic grad_t grad_of(input logic [3:0] h);
        grad_t g;
        case (h)
            4'd0:    g = '{gx: 2'sd1,  gy: 2'sd1,  gz: 2'sd0};
            4'd1:    g = '{gx: -2'sd1, gy: 2'sd1,  gz: 2'sd0};
            4'd2:    g = '{gx: 2'sd1,  gy: -2'sd1, gz: 2'sd0};
            4'd3:    g = '{gx: -2'sd1, gy: -2'sd1, gz: 2'sd0};
            4'd4:    g = '{gx: 2'sd1,  gy: 2'sd0,  gz: 2'sd1};
            4'd5:    g = '{gx: -2'sd1, gy: 2'sd0,  gz: 2'sd1};
            4'd6:    g = '{gx: 2'sd1,  gy: 2'sd0,  gz: -2'sd1};
            4'd7:    g = '{gx: -2'sd1, gy: 2'sd0,  gz: -2'sd1};
            4'd8:    g = '{gx: 2'sd0,  gy: 2'sd1,  gz: 2'sd1};
            4'd9:    g = '{gx: 2'sd0,  gy: -2'sd1, gz: 2'sd1};
            4'd10:   g = '{gx: 2'sd0,  gy: 2'sd1,  gz: -2'sd1};
            4'd11:   g = '{gx: 2'sd0,  gy: -2'sd1, gz: -2'sd1};
            4'd12:   g = '{gx: 2'sd1,  gy: 2'sd1,  gz: 2'sd0};
            4'd13:   g = '{gx: -2'sd1, gy: 2'sd1,  gz: 2'sd0};
            4'd14:   g = '{gx: 2'sd0,  gy: -2'sd1, gz: 2'sd1};
            default: g = '{gx: 2'sd0,  gy: -2'sd1, gz: -2'sd1};
        endcase
        return g;
    endfunction

    function automatic logic signed [VAL_W-1:0] term(input logic signed [1:0] g,
                                                     input logic signed [DELTA_W-1:0] d);
        logic signed [VAL_W-1:0] dx;
        dx = VAL_W'(d);
        if (g == 2'sd1) begin
            return dx;
        end else if (g == -2'sd1) begin
            return -dx;
        end
        return '0;
    endfunction

endpackage

>>> rtl/core/gn23_perm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn23_perm_ram
// One copy of the permutation table: one write port, one registered read.
// ----------------------------------------------------------------------------
module gn23_perm_ram (
    input  logic                          aclk,
    input  logic                          en,
    input  logic                          we,
    input  logic [gn23_pkg::HASH_W-1:0]   waddr,
    input  logic [gn23_pkg::HASH_W-1:0]   wdata,
    input  logic [gn23_pkg::HASH_W-1:0]   raddr,
    output logic [gn23_pkg::HASH_W-1:0]   rdata
);

    logic [gn23_pkg::HASH_W-1:0] mem [gn23_pkg::PERM_SIZE];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/gn23_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn23_fade
// Three-stage quintic fade 6t^5-15t^4+10t^3 on an unsigned fraction.
// ----------------------------------------------------------------------------
module gn23_fade (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [gn23_pkg::FRAC_BITS-1:0] frac,
    output logic [gn23_pkg::FADE_W-1:0]    fade
);

    localparam int FB = gn23_pkg::FRAC_BITS;
    localparam int QW = FB + 8;

    logic signed [QW-1:0]     q;
    logic signed [QW+FB:0]    m1;
    logic [2*FB-1:0]          m2;
    logic signed [QW:0]       m1_reg;
    logic [FB-1:0]            sq_reg;
    logic [FB-1:0]            t1_reg;
    logic signed [QW:0]       inner_full;
    logic [2*FB-1:0]          cube_full;
    logic [FB+3:0]            inner_reg;
    logic [FB-1:0]            cube_reg;
    logic [2*FB+3:0]          prod;

    assign q          = $signed({8'd0, frac}) * QW'(6) - (QW'(15) <<< FB);
    assign m1         = $signed({1'b0, frac}) * q;
    assign m2         = frac * frac;
    assign inner_full = m1_reg + ((QW + 1)'(10) <<< FB);
    assign cube_full  = sq_reg * t1_reg;
    assign prod       = cube_reg * inner_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_reg    <= (QW + 1)'(m1 >>> FB);
            sq_reg    <= m2[2*FB-1:FB];
            t1_reg    <= frac;
            inner_reg <= inner_full[FB+3:0];
            cube_reg  <= cube_full[2*FB-1:FB];
            fade      <= prod[FB+gn23_pkg::FADE_W-1:FB];
        end
    end

endmodule

>>> rtl/core/gn23_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gn23_lerp
// Registered linear interpolation a + floor((b - a) * t).
// ----------------------------------------------------------------------------
module gn23_lerp (
    input  logic                                 aclk,
    input  logic                                 en,
    input  logic signed [gn23_pkg::VAL_W-1:0]    a,
    input  logic signed [gn23_pkg::VAL_W-1:0]    b,
    input  logic [gn23_pkg::FADE_W-1:0]          t,
    output logic signed [gn23_pkg::VAL_W-1:0]    y
);

    localparam int VW = gn23_pkg::VAL_W;
    localparam int FW = gn23_pkg::FADE_W;

    logic signed [VW:0]      diff;
    logic signed [VW+FW+1:0] prod;

    assign diff = (VW + 1)'(b) - (VW + 1)'(a);
    assign prod = diff * $signed({1'b0, t});

    always_ff @(posedge aclk) begin
        if (en) begin
            y <= a + VW'(prod >>> gn23_pkg::FRAC_BITS);
        end
    end

endmodule

>>> rtl/core/gradient_noise_2d_3d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_2d_3d_core
// Pipelined 2D/3D gradient noise with a loadable permutation table.
//
//   Channel  Direction  Transfer carries
//   s_       in         request type, Q16.16 coordinates, table entry/value
//   m_       out        Q3.16 noise value (none for load requests)
//
// One request enters per cycle while the output is not stalled.
// Three table lookups run in stages 1 to 3, each stage on its own table
// copies; a load writes each copy group as it passes that group's stage.
// A stall at the output freezes the whole pipeline, nothing is dropped.
// Reset clears the valid bits; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_2d_3d_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_req_type,
    input  logic signed [31:0]  s_coord_x,
    input  logic signed [31:0]  s_coord_y,
    input  logic signed [31:0]  s_coord_z,
    input  logic [7:0]          s_entry_index,
    input  logic [7:0]          s_entry_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [19:0]  m_noise_value
);

    localparam int FB = gn23_pkg::FRAC_BITS;
    localparam int HW = gn23_pkg::HASH_W;
    localparam int VW = gn23_pkg::VAL_W;
    localparam int FW = gn23_pkg::FADE_W;
    localparam int DW = gn23_pkg::DELTA_W;

    logic en;
    logic [7:1] v_reg;
    gn23_pkg::req_type_t typ_reg [7:1];
    logic [HW-1:0] i_reg [3:1];
    logic [HW-1:0] j_reg [2:1];
    logic [HW-1:0] k1_reg;
    logic [FB-1:0] u_reg [4:1];
    logic [FB-1:0] w_reg [4:1];
    logic [FB-1:0] y_reg [4:1];
    logic [HW-1:0] idx_reg [3:1];
    logic [HW-1:0] val_reg [3:1];
    logic [HW-1:0] ha [2];
    logic [HW-1:0] hb [4];
    logic [HW-1:0] hc [8];
    logic [HW-1:0] hb4_reg [4];
    logic [HW-1:0] ra_a [2];
    logic [HW-1:0] ra_b [4];
    logic [HW-1:0] ra_c [8];
    logic [HW-1:0] base_a;
    logic [HW-1:0] base_b;
    logic we_a, we_b, we_c;
    logic [FW-1:0] fu, fv, fw;
    logic [FW-1:0] fu5_reg, fv5_reg, fw5_reg, fu6_reg, fv6_reg, fu7_reg;
    logic signed [VW-1:0] dot [8];
    logic signed [VW-1:0] f5_reg [8];
    logic signed [VW-1:0] l6 [4];
    logic signed [VW-1:0] l7 [2];
    logic signed [VW-1:0] l8;
    logic v8_reg;

    assign m_valid       = v8_reg;
    assign en            = !v8_reg || m_ready;
    assign s_ready       = en;
    assign m_noise_value = l8[gn23_pkg::OUT_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            v8_reg <= 1'b0;
        end else if (en) begin
            v_reg  <= {v_reg[6:1], s_valid};
            v8_reg <= v_reg[7] && (typ_reg[7] == gn23_pkg::REQ_NOISE2D
                                   || typ_reg[7] == gn23_pkg::REQ_NOISE3D);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            typ_reg[1] <= gn23_pkg::req_type_t'(s_req_type);
            for (int n = 2; n <= 7; n++) begin
                typ_reg[n] <= typ_reg[n-1];
            end
            i_reg[1]   <= s_coord_x[FB+HW-1:FB];
            j_reg[1]   <= s_coord_y[FB+HW-1:FB];
            k1_reg     <= s_coord_z[FB+HW-1:FB];
            u_reg[1]   <= s_coord_x[FB-1:0];
            y_reg[1]   <= s_coord_y[FB-1:0];
            w_reg[1]   <= s_coord_z[FB-1:0];
            idx_reg[1] <= s_entry_index;
            val_reg[1] <= s_entry_value;
            i_reg[2]   <= i_reg[1];
            i_reg[3]   <= i_reg[2];
            j_reg[2]   <= j_reg[1];
            for (int n = 2; n <= 4; n++) begin
                u_reg[n] <= u_reg[n-1];
                y_reg[n] <= y_reg[n-1];
                w_reg[n] <= w_reg[n-1];
            end
            for (int n = 2; n <= 3; n++) begin
                idx_reg[n] <= idx_reg[n-1];
                val_reg[n] <= val_reg[n-1];
            end
            for (int n = 0; n < 4; n++) begin
                hb4_reg[n] <= hb[n];
            end
            for (int n = 0; n < 8; n++) begin
                f5_reg[n] <= dot[n];
            end
            fu5_reg <= fu;
            fv5_reg <= fv;
            fw5_reg <= fw;
            fu6_reg <= fu5_reg;
            fv6_reg <= fv5_reg;
            fu7_reg <= fu6_reg;
        end
    end

    assign we_a = en && v_reg[1] && typ_reg[1] == gn23_pkg::REQ_LOAD;
    assign we_b = en && v_reg[2] && typ_reg[2] == gn23_pkg::REQ_LOAD;
    assign we_c = en && v_reg[3] && typ_reg[3] == gn23_pkg::REQ_LOAD;

    assign base_a = (typ_reg[1] == gn23_pkg::REQ_NOISE3D) ? k1_reg : j_reg[1];
    assign base_b = (typ_reg[2] == gn23_pkg::REQ_NOISE3D) ? j_reg[2] : i_reg[2];

    always_comb begin
        for (int c = 0; c < 2; c++) begin
            ra_a[c] = base_a + HW'(c);
        end
        for (int n = 0; n < 4; n++) begin
            ra_b[n] = base_b + HW'(n / 2) + ha[n % 2];
        end
        for (int m = 0; m < 8; m++) begin
            ra_c[m] = i_reg[3] + HW'(m / 4) + hb[m % 4];
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_ram_a
        gn23_perm_ram u_ram (
            .aclk (aclk), .en (en), .we (we_a), .waddr (idx_reg[1]),
            .wdata (val_reg[1]), .raddr (ra_a[g]), .rdata (ha[g])
        );
    end
    for (genvar g = 0; g < 4; g++) begin : g_ram_b
        gn23_perm_ram u_ram (
            .aclk (aclk), .en (en), .we (we_b), .waddr (idx_reg[2]),
            .wdata (val_reg[2]), .raddr (ra_b[g]), .rdata (hb[g])
        );
    end
    for (genvar g = 0; g < 8; g++) begin : g_ram_c
        gn23_perm_ram u_ram (
            .aclk (aclk), .en (en), .we (we_c), .waddr (idx_reg[3]),
            .wdata (val_reg[3]), .raddr (ra_c[g]), .rdata (hc[g])
        );
    end

    gn23_fade u_fade_x (.aclk (aclk), .en (en), .frac (u_reg[1]), .fade (fu));
    gn23_fade u_fade_y (.aclk (aclk), .en (en), .frac (y_reg[1]), .fade (fv));
    gn23_fade u_fade_z (.aclk (aclk), .en (en), .frac (w_reg[1]), .fade (fw));

    // In 2D each corner fills both z slots, so the first blend level leaves it unchanged.
    always_comb begin
        logic [HW-1:0]          h;
        logic signed [DW-1:0]   dx, dy, dz;
        gn23_pkg::grad_t        g;
        for (int m = 0; m < 8; m++) begin
            dx = $signed({2'b00, u_reg[4]}) - ((m / 4 == 1) ? (DW'(1) <<< FB) : '0);
            dy = $signed({2'b00, y_reg[4]}) - (((m / 2) % 2 == 1) ? (DW'(1) <<< FB) : '0);
            if (typ_reg[4] == gn23_pkg::REQ_NOISE3D) begin
                h  = hc[m];
                dz = $signed({2'b00, w_reg[4]}) - ((m % 2 == 1) ? (DW'(1) <<< FB) : '0);
            end else begin
                h  = hb4_reg[m / 2];
                dz = '0;
            end
            g = gn23_pkg::grad_of(h[3:0]);
            dot[m] = gn23_pkg::term(g.gx, dx) + gn23_pkg::term(g.gy, dy)
                   + gn23_pkg::term(g.gz, dz);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lerp_z
        gn23_lerp u_lerp (
            .aclk (aclk), .en (en), .a (f5_reg[2*g]), .b (f5_reg[2*g+1]),
            .t (fw5_reg), .y (l6[g])
        );
    end
    for (genvar g = 0; g < 2; g++) begin : g_lerp_y
        gn23_lerp u_lerp (
            .aclk (aclk), .en (en), .a (l6[2*g]), .b (l6[2*g+1]),
            .t (fv6_reg), .y (l7[g])
        );
    end
    gn23_lerp u_lerp_x (
        .aclk (aclk), .en (en), .a (l7[0]), .b (l7[1]), .t (fu7_reg), .y (l8)
    );

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(v_reg) && $stable(v8_reg))
        else $error("Pipeline valid bits moved during a stall.");

    a_load_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        we_a |=> v_reg[2] && typ_reg[2] == gn23_pkg::REQ_LOAD)
        else $error("Table load did not advance to the second copy group.");

    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v_reg[7] && typ_reg[7] == gn23_pkg::REQ_LOAD) |=> !m_valid)
        else $error("A load request produced a result transfer.");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> l8[VW-1] == l8[gn23_pkg::OUT_W-1])
        else $error("Noise value exceeds the output range.");

endmodule
